[rtl/core/frs_pkg.sv]
package frs_pkg;

   // Window length and rate scaling
   localparam logic [31:0] WINDOW_MS     = 32'd1000;
   localparam logic [9:0]  MS_PER_S      = 10'd1000;
   localparam logic [23:0] RATE_MAX      = 24'hFFFFFF;
   localparam logic [23:0] WORST_INIT    = 24'd255744;
   localparam logic [31:0] SHORTEST_INIT = 32'd999999;
   localparam logic [31:0] COUNT_MAX     = 32'hFFFFFFFF;

   // Event codes
   localparam logic FUNC_RESTART = 1'b0;
   localparam logic FUNC_FRAME   = 1'b1;

   // Input queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Rate divider: one quotient bit per step
   localparam int DIV_STEPS = 24;
   localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
   localparam int PROD_W    = 42;
   localparam int HI_W      = PROD_W - 16;

   typedef struct packed {
      logic        func;
      logic [31:0] timestamp_ms;
   } item_type;

   typedef struct packed {
      logic             start;
      logic [HI_W-1:0]  hi;
      logic [23:0]      lo;
      logic [31:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [23:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT
   } back_state_type;

endpackage

[rtl/core/frs_front.sv]
module frs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  frs_pkg::item_type  push_item,
   output logic               q_valid,
   input  logic               q_pop,
   output frs_pkg::item_type  q_item
);

   frs_pkg::item_type                 slot_ff [frs_pkg::QUEUE_DEPTH];
   logic [frs_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [frs_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [frs_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              wr_en;
   logic                              rd_en;

   assign full    = (count_ff == frs_pkg::QCNT_W'(frs_pkg::QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign wr_en   = push && !full;
   assign rd_en   = q_pop && q_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store items
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign q_item = slot_ff[rd_ptr_ff];

endmodule

[rtl/core/frs_div.sv]
module frs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  frs_pkg::div_req_type  req,
   output frs_pkg::div_rsp_type  rsp
);

   logic [31:0]                 rem_ff, rem_in;
   logic [23:0]                 lo_ff, lo_in;
   logic [23:0]                 quo_ff, quo_in;
   logic [31:0]                 div_ff, div_in;
   logic [frs_pkg::DCNT_W-1:0]  cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [32:0]                 trial;
   logic [32:0]                 diff;
   logic                        fits;

   // One restoring step: bring down the next dividend bit
   always_comb begin
      trial = {rem_ff, lo_ff[23]};
      diff  = trial - {1'b0, div_ff};
      fits  = (trial >= {1'b0, div_ff});
   end

   always_comb begin
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         div_in = req.divisor;
         if (32'(req.hi) >= req.divisor) begin
            // Quotient does not fit: saturate
            quo_in = frs_pkg::RATE_MAX;
            done_in = 1'b1;
         end else begin
            rem_in  = 32'(req.hi);
            lo_in   = req.lo;
            quo_in  = '0;
            cnt_in  = frs_pkg::DCNT_W'(frs_pkg::DIV_STEPS);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = fits ? diff[31:0] : trial[31:0];
         quo_in = {quo_ff[22:0], fits};
         lo_in  = {lo_ff[22:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == frs_pkg::DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   // Remainder stays below the divisor while iterating
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < div_ff)
      else $error("divider remainder not below divisor");

   // A busy divider always has steps left
   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with no steps left");

endmodule

[rtl/core/frs_back.sv]
module frs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  frs_pkg::item_type     q_item,
   output frs_pkg::div_req_type  div_req,
   input  frs_pkg::div_rsp_type  div_rsp,
   output logic                  empty,
   input  logic                  pop,
   output logic [31:0]           frames_in_window,
   output logic [31:0]           shortest_frame_ms,
   output logic [31:0]           longest_frame_ms,
   output logic [23:0]           current_rate,
   output logic [23:0]           average_rate,
   output logic [23:0]           best_rate,
   output logic [23:0]           worst_rate,
   output logic                  window_closed
);

   frs_pkg::back_state_type       state_ff, state_in;
   frs_pkg::item_type             item_ff, item_in;
   logic [31:0]                   last_time_ff, last_time_in;
   logic [31:0]                   start_time_ff, start_time_in;
   logic [31:0]                   count_ff, count_in;
   logic [31:0]                   shortest_ff, shortest_in;
   logic [31:0]                   longest_ff, longest_in;
   logic [23:0]                   last_rate_ff, last_rate_in;
   logic [23:0]                   mean_rate_ff, mean_rate_in;
   logic [23:0]                   top_rate_ff, top_rate_in;
   logic [23:0]                   bottom_rate_ff, bottom_rate_in;
   logic [31:0]                   elapsed_ff, elapsed_in;
   logic [frs_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic                          closed_ff, closed_in;
   logic                          out_valid_ff, out_valid_in;
   logic [31:0]                   dur;
   logic [31:0]                   elapsed;
   logic [24:0]                   mean_sum;
   logic [23:0]                   rate;
   logic                          div_start;

   assign dur      = item_ff.timestamp_ms - last_time_ff;
   assign elapsed  = item_ff.timestamp_ms - start_time_ff;
   assign rate     = div_rsp.quotient;
   assign mean_sum = {1'b0, mean_rate_ff} + {1'b0, rate};

   // Divider operands: count * 256000 split at bit 24
   assign div_req.start   = div_start;
   assign div_req.hi      = prod_ff[frs_pkg::PROD_W-1:16];
   assign div_req.lo      = {prod_ff[15:0], 8'b0};
   assign div_req.divisor = elapsed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= frs_pkg::ST_IDLE;
         out_valid_ff   <= 1'b0;
         closed_ff      <= 1'b0;
         last_time_ff   <= '0;
         start_time_ff  <= '0;
         count_ff       <= '0;
         shortest_ff    <= frs_pkg::SHORTEST_INIT;
         longest_ff     <= '0;
         last_rate_ff   <= '0;
         mean_rate_ff   <= '0;
         top_rate_ff    <= '0;
         bottom_rate_ff <= frs_pkg::WORST_INIT;
      end else begin
         state_ff       <= state_in;
         out_valid_ff   <= out_valid_in;
         closed_ff      <= closed_in;
         last_time_ff   <= last_time_in;
         start_time_ff  <= start_time_in;
         count_ff       <= count_in;
         shortest_ff    <= shortest_in;
         longest_ff     <= longest_in;
         last_rate_ff   <= last_rate_in;
         mean_rate_ff   <= mean_rate_in;
         top_rate_ff    <= top_rate_in;
         bottom_rate_ff <= bottom_rate_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      elapsed_ff <= elapsed_in;
      prod_ff    <= prod_in;
   end

   // Sequence one item through the statistics update
   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      last_time_in   = last_time_ff;
      start_time_in  = start_time_ff;
      count_in       = count_ff;
      shortest_in    = shortest_ff;
      longest_in     = longest_ff;
      last_rate_in   = last_rate_ff;
      mean_rate_in   = mean_rate_ff;
      top_rate_in    = top_rate_ff;
      bottom_rate_in = bottom_rate_ff;
      elapsed_in     = elapsed_ff;
      prod_in        = prod_ff;
      closed_in      = closed_ff;
      out_valid_in   = out_valid_ff && !pop;
      q_pop          = 1'b0;
      div_start      = 1'b0;
      unique case (state_ff)
         frs_pkg::ST_IDLE: begin
            // Take the next item once the last result is gone
            if (q_valid && !out_valid_ff) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = frs_pkg::ST_STEP;
            end
         end
         frs_pkg::ST_STEP: begin
            if (item_ff.func == frs_pkg::FUNC_RESTART) begin
               last_time_in   = item_ff.timestamp_ms;
               start_time_in  = item_ff.timestamp_ms;
               count_in       = '0;
               shortest_in    = frs_pkg::SHORTEST_INIT;
               longest_in     = '0;
               last_rate_in   = '0;
               mean_rate_in   = '0;
               top_rate_in    = '0;
               bottom_rate_in = frs_pkg::WORST_INIT;
               closed_in      = 1'b0;
               out_valid_in   = 1'b1;
               state_in       = frs_pkg::ST_IDLE;
            end else begin
               if (count_ff != frs_pkg::COUNT_MAX) begin
                  count_in = count_ff + 32'd1;
               end
               last_time_in = item_ff.timestamp_ms;
               if (dur < shortest_ff) begin
                  shortest_in = dur;
               end
               if (dur > longest_ff) begin
                  longest_in = dur;
               end
               elapsed_in = elapsed;
               if (elapsed > frs_pkg::WINDOW_MS) begin
                  state_in = frs_pkg::ST_MUL;
               end else begin
                  closed_in    = 1'b0;
                  out_valid_in = 1'b1;
                  state_in     = frs_pkg::ST_IDLE;
               end
            end
         end
         frs_pkg::ST_MUL: begin
            // Scale the frame count to frames per second
            prod_in  = frs_pkg::PROD_W'(count_ff) * frs_pkg::PROD_W'(frs_pkg::MS_PER_S);
            state_in = frs_pkg::ST_DIV_START;
         end
         frs_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = frs_pkg::ST_DIV_WAIT;
         end
         frs_pkg::ST_DIV_WAIT: begin
            // Close the window with the new rate
            if (div_rsp.done) begin
               last_rate_in = rate;
               if (mean_rate_ff == '0) begin
                  mean_rate_in = rate;
               end else begin
                  mean_rate_in = mean_sum[24:1];
               end
               if (rate > top_rate_ff) begin
                  top_rate_in = rate;
               end
               if (rate < bottom_rate_ff) begin
                  bottom_rate_in = rate;
               end
               start_time_in = item_ff.timestamp_ms;
               count_in      = '0;
               closed_in     = 1'b1;
               out_valid_in  = 1'b1;
               state_in      = frs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frs_pkg::ST_IDLE;
         end
      endcase
   end

   assign empty             = !out_valid_ff;
   assign frames_in_window  = count_ff;
   assign shortest_frame_ms = shortest_ff;
   assign longest_frame_ms  = longest_ff;
   assign current_rate      = last_rate_ff;
   assign average_rate      = mean_rate_ff;
   assign best_rate         = top_rate_ff;
   assign worst_rate        = bottom_rate_ff;
   assign window_closed     = closed_ff;

   // A waiting result holds the sequencer idle
   a_hold_while_full: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> state_ff == frs_pkg::ST_IDLE)
      else $error("sequencer busy while result waits");

   // A closed window leaves an empty count
   a_closed_count: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && closed_ff |-> count_ff == '0)
      else $error("closed window with nonzero count");

endmodule

[rtl/core/frame_rate_statistics.sv]
// Frame rate statistics. Push a restart or a frame-finished event with its
// millisecond timestamp; each event gives exactly one result item holding the
// statistics after that event. An input queue of two items takes events while
// the sequencer works, and the sequencer starts the next event only once the
// previous result has been popped. A restart, or a frame that leaves the
// window open, has its result written in the step state. A frame that
// closes the window goes on through the multiply, divider start and divider
// wait states: the rate frames*256000/elapsed comes from a restoring divider
// that produces one of its 24 quotient bits per cycle, and a saturated rate
// skips those steps.
module frame_rate_statistics (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_func,
   input  logic [31:0] req_timestamp_ms,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_frames_in_window,
   output logic [31:0] rsp_shortest_frame_ms,
   output logic [31:0] rsp_longest_frame_ms,
   output logic [23:0] rsp_current_rate,
   output logic [23:0] rsp_average_rate,
   output logic [23:0] rsp_best_rate,
   output logic [23:0] rsp_worst_rate,
   output logic        rsp_window_closed
);

   frs_pkg::item_type     push_item;
   frs_pkg::item_type     q_item;
   logic                  q_valid;
   logic                  q_pop;
   frs_pkg::div_req_type  div_req;
   frs_pkg::div_rsp_type  div_rsp;

   assign push_item.func         = req_func;
   assign push_item.timestamp_ms = req_timestamp_ms;

   frs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .push_item (push_item),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item)
   );

   frs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   frs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_item            (q_item),
      .div_req           (div_req),
      .div_rsp           (div_rsp),
      .empty             (empty),
      .pop               (pop),
      .frames_in_window  (rsp_frames_in_window),
      .shortest_frame_ms (rsp_shortest_frame_ms),
      .longest_frame_ms  (rsp_longest_frame_ms),
      .current_rate      (rsp_current_rate),
      .average_rate      (rsp_average_rate),
      .best_rate         (rsp_best_rate),
      .worst_rate        (rsp_worst_rate),
      .window_closed     (rsp_window_closed)
   );

endmodule

[sim/frame_rate_statistics_tb.sv]
`timescale 1ns / 1ps

module frame_rate_statistics_tb;

   localparam logic [63:0] RATE_SCALE   = 64'd256000;
   localparam int          RANDOM_ITEMS = 520;
   localparam int          STALL_LIMIT  = 2000;
   localparam int          DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [31:0] frames;
      logic [31:0] shortest;
      logic [31:0] longest;
      logic [23:0] current;
      logic [23:0] average;
      logic [23:0] best;
      logic [23:0] worst;
      logic        closed;
   } frame_stats_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_func = frs_pkg::FUNC_RESTART;
   logic [31:0] req_timestamp_ms = 32'd0;
   logic        empty;
   logic        pop = 1'b0;
   logic [31:0] rsp_frames_in_window;
   logic [31:0] rsp_shortest_frame_ms;
   logic [31:0] rsp_longest_frame_ms;
   logic [23:0] rsp_current_rate;
   logic [23:0] rsp_average_rate;
   logic [23:0] rsp_best_rate;
   logic [23:0] rsp_worst_rate;
   logic        rsp_window_closed;

   // Predicted statistics state
   logic [31:0] prev_frame_ms;
   logic [31:0] window_open_ms;
   logic [31:0] window_frames;
   logic [31:0] min_dur;
   logic [31:0] max_dur;
   logic [23:0] rate_now;
   logic [23:0] rate_avg;
   logic [23:0] rate_high;
   logic [23:0] rate_low;

   frame_stats_type expected_stats[$];
   int unsigned     error_count = 0;
   bit              idling = 1'b1;
   int unsigned     pop_hold = 0;

   frame_rate_statistics i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_func              (req_func),
      .req_timestamp_ms      (req_timestamp_ms),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_frames_in_window  (rsp_frames_in_window),
      .rsp_shortest_frame_ms (rsp_shortest_frame_ms),
      .rsp_longest_frame_ms  (rsp_longest_frame_ms),
      .rsp_current_rate      (rsp_current_rate),
      .rsp_average_rate      (rsp_average_rate),
      .rsp_best_rate         (rsp_best_rate),
      .rsp_worst_rate        (rsp_worst_rate),
      .rsp_window_closed     (rsp_window_closed)
   );

   always #5 clock = ~clock;

   // Pick an idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!idling) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Return every statistic to its restart value
   task automatic clear_statistics(input logic [31:0] stamp);
      prev_frame_ms  = stamp;
      window_open_ms = stamp;
      window_frames  = 32'd0;
      min_dur        = frs_pkg::SHORTEST_INIT;
      max_dur        = 32'd0;
      rate_now       = 24'd0;
      rate_avg       = 24'd0;
      rate_high      = 24'd0;
      rate_low       = frs_pkg::WORST_INIT;
   endtask

   // Apply one event to the predicted state and queue the statistics it yields
   task automatic update_statistics(input logic func, input logic [31:0] stamp);
      logic [31:0]     dur;
      logic [31:0]     elapsed;
      logic [63:0]     quotient;
      logic [23:0]     rate;
      logic [24:0]     rate_sum;
      logic            closed;
      frame_stats_type stats;
      closed = 1'b0;
      if (func == frs_pkg::FUNC_RESTART) begin
         clear_statistics(stamp);
      end else begin
         if (window_frames != frs_pkg::COUNT_MAX) window_frames = window_frames + 32'd1;
         dur = stamp - prev_frame_ms;
         prev_frame_ms = stamp;
         if (dur < min_dur) min_dur = dur;
         if (dur > max_dur) max_dur = dur;
         elapsed = stamp - window_open_ms;
         // Close the window once it is longer than WINDOW_MS
         if (elapsed > frs_pkg::WINDOW_MS) begin
            quotient = ({32'd0, window_frames} * RATE_SCALE) / {32'd0, elapsed};
            rate = (quotient > {40'd0, frs_pkg::RATE_MAX}) ? frs_pkg::RATE_MAX
                                                            : quotient[23:0];
            rate_now = rate;
            if (rate_avg == 24'd0) begin
               rate_avg = rate;
            end else begin
               rate_sum = {1'b0, rate_avg} + {1'b0, rate};
               rate_avg = rate_sum[24:1];
            end
            if (rate > rate_high) rate_high = rate;
            if (rate < rate_low) rate_low = rate;
            window_open_ms = stamp;
            window_frames  = 32'd0;
            closed = 1'b1;
         end
      end
      stats.frames   = window_frames;
      stats.shortest = min_dur;
      stats.longest  = max_dur;
      stats.current  = rate_now;
      stats.average  = rate_avg;
      stats.best     = rate_high;
      stats.worst    = rate_low;
      stats.closed   = closed;
      expected_stats.push_back(stats);
   endtask

   // Push one item after a random gap; keep push high across back-to-back items
   task automatic send_event(input logic func, input logic [31:0] stamp);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_func <= func;
      req_timestamp_ms <= stamp;
      do @(posedge clock); while (full);
      update_statistics(func, stamp);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Drive pop with random stalls
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (pop_hold != 0) begin
         pop <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else begin
         pop <= 1'b1;
         pop_hold <= pick_gap();
      end
   end

   // Compare each popped item with the oldest prediction
   always @(posedge clock) begin : result_check
      frame_stats_type want;
      if (!reset && pop && !empty) begin
         if (expected_stats.size() == 0) begin
            $display("%0t: result item with none expected, frames %0d", $time,
                     rsp_frames_in_window);
            error_count++;
         end else begin
            want = expected_stats.pop_front();
            compare_field("frames_in_window", want.frames, rsp_frames_in_window);
            compare_field("shortest_frame_ms", want.shortest, rsp_shortest_frame_ms);
            compare_field("longest_frame_ms", want.longest, rsp_longest_frame_ms);
            compare_field("current_rate", {8'd0, want.current}, {8'd0, rsp_current_rate});
            compare_field("average_rate", {8'd0, want.average}, {8'd0, rsp_average_rate});
            compare_field("best_rate", {8'd0, want.best}, {8'd0, rsp_best_rate});
            compare_field("worst_rate", {8'd0, want.worst}, {8'd0, rsp_worst_rate});
            compare_field("window_closed", {31'd0, want.closed}, {31'd0, rsp_window_closed});
         end
      end
   end

   // End the run when nothing moves on either side for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      @(negedge reset);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) quiet = 0;
         else quiet++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Frames measured against the reset times, then the window edge at 1000 ms
   task automatic test_frame_before_restart();
      idling = 1'b1;
      send_event(frs_pkg::FUNC_FRAME, 32'd500);
      send_event(frs_pkg::FUNC_FRAME, 32'd1000);
      send_event(frs_pkg::FUNC_FRAME, 32'd1001);
      send_event(frs_pkg::FUNC_FRAME, 32'd1001);
   endtask

   // Windows that straddle the 32-bit timestamp wrap
   task automatic test_timestamp_wrap();
      send_event(frs_pkg::FUNC_RESTART, 32'hFFFF_FE00);
      send_event(frs_pkg::FUNC_FRAME, 32'hFFFF_FF80);
      send_event(frs_pkg::FUNC_FRAME, 32'h0000_0100);
      send_event(frs_pkg::FUNC_FRAME, 32'h0000_01F0);
      send_event(frs_pkg::FUNC_RESTART, 32'hFFFF_FFFF);
      send_event(frs_pkg::FUNC_FRAME, 32'h0000_0000);
   endtask

   // A timestamp that goes backwards reads as a huge interval
   task automatic test_backward_timestamp();
      send_event(frs_pkg::FUNC_RESTART, 32'h8000_0000);
      send_event(frs_pkg::FUNC_FRAME, 32'h8000_0010);
      send_event(frs_pkg::FUNC_FRAME, 32'h7FFF_FFF0);
      send_event(frs_pkg::FUNC_FRAME, 32'h7FFF_FFF0);
      send_event(frs_pkg::FUNC_FRAME, 32'h8000_03F0);
   endtask

   // Longest and zero durations, and back-to-back restarts
   task automatic test_extreme_durations();
      send_event(frs_pkg::FUNC_RESTART, 32'd0);
      send_event(frs_pkg::FUNC_FRAME, 32'hFFFF_FFFF);
      send_event(frs_pkg::FUNC_FRAME, 32'hFFFF_FFFF);
      send_event(frs_pkg::FUNC_RESTART, 32'h5555_5555);
      send_event(frs_pkg::FUNC_RESTART, 32'hAAAA_AAAA);
      send_event(frs_pkg::FUNC_FRAME, 32'hAAAA_AAAA);
   endtask

   // Dense windows sent back to back, then sparse ones
   task automatic test_dense_windows();
      logic [31:0] base;
      idling = 1'b0;
      base = 32'h1234_5678;
      send_event(frs_pkg::FUNC_RESTART, base);
      repeat (150) send_event(frs_pkg::FUNC_FRAME, base);
      send_event(frs_pkg::FUNC_FRAME, base + 32'd1001);
      repeat (50) send_event(frs_pkg::FUNC_FRAME, base + 32'd1001);
      send_event(frs_pkg::FUNC_FRAME, base + 32'd2002);
      send_event(frs_pkg::FUNC_FRAME, base + 32'd3502);
   endtask

   // Pick a frame-to-frame step: mostly short, sometimes window sized, rarely any
   function automatic logic [31:0] pick_step();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) return 32'd0;
      if (r < 85) return $urandom_range(1, 100);
      if (r < 95) return $urandom_range(100, 1200);
      return $urandom;
   endfunction

   // Restart-led frame sequences with random content, plus stray items
   task automatic test_random_sequences();
      int unsigned sent;
      int unsigned r;
      int unsigned n;
      logic [31:0] stamp;
      sent = 0;
      stamp = 32'd0;
      while (sent < RANDOM_ITEMS) begin
         idling = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 99);
         if (r < 8) begin
            send_event(1'($urandom_range(0, 1)), $urandom);
            sent++;
         end else begin
            if (r < 80) begin
               if ($urandom_range(0, 7) == 0) stamp = 32'hFFFF_F000 + $urandom_range(0, 4095);
               else stamp = $urandom;
               send_event(frs_pkg::FUNC_RESTART, stamp);
               sent++;
            end
            n = $urandom_range(10, 60);
            repeat (n) begin
               stamp = stamp + pick_step();
               send_event(frs_pkg::FUNC_FRAME, stamp);
            end
            sent += n;
         end
      end
   endtask

   initial begin
      clear_statistics(32'd0);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_frame_before_restart();
      test_timestamp_wrap();
      test_backward_timestamp();
      test_extreme_durations();
      test_dense_windows();
      test_random_sequences();
      push <= 1'b0;
      while (expected_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
